### hw/rtl/two_pass_sample_statistics_core_defines.svh
// assertion macros shared by the checker of two_pass_sample_statistics_core
// depends on nothing; included by the checker file
`ifndef TWO_PASS_SAMPLE_STATISTICS_CORE_DEFINES_SVH
`define TWO_PASS_SAMPLE_STATISTICS_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define TPSS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define TPSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tpss_pkg.sv
// types, widths and codes of the two-pass sample statistics core
// depends on nothing; used by every module of the block
package tpss_pkg;

  localparam int unsigned COUNT_MAX_DEF      = 65536;
  localparam int unsigned MEAN_FRAC_BITS_DEF = 8;

  localparam int SAMPLE_W   = 16;
  localparam int CNT_W      = 17;
  localparam int SUM_W      = 32;
  localparam int MEAN_W     = 24;
  localparam int STD_W      = 24;
  localparam int SQ_W       = 64;
  localparam int DEV_W      = 26;
  localparam int MAG_W      = 25;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int DVSR_W     = CNT_W + 1;
  localparam int ROOT_W     = SQ_W / 2;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int DIV_STEPS  = SQ_W;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [MEAN_W-2:0] MEAN_MAX = '1;
  localparam logic [STD_W-1:0]  STD_MAX  = '1;

  localparam logic MODE_PASS1 = 1'b0;
  localparam logic MODE_PASS2 = 1'b1;
  localparam logic KIND_STATS = 1'b0;
  localparam logic KIND_STD   = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_t;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] min_value;
    logic signed [SAMPLE_W-1:0] max_value;
    logic signed [MEAN_W-1:0]   mean_value;
    logic [STD_W-1:0]           std_value;
    logic                       overflowed;
  } out_t;

  // snapshot of one finished pass, handed from front to back
  typedef struct packed {
    logic                       kind;
    logic                       overflowed;
    logic signed [SAMPLE_W-1:0] min_value;
    logic signed [SAMPLE_W-1:0] max_value;
    logic signed [SUM_W-1:0]    sum;
    logic [CNT_W-1:0]           count;
    logic [SQ_W-1:0]            sq_sum;
    logic signed [MEAN_W-1:0]   mean;
  } job_t;

  typedef struct packed {
    logic                     valid;
    logic signed [MEAN_W-1:0] value;
  } mean_upd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_FIN
  } back_state_t;

endpackage

### hw/rtl/tpss_front.sv
// front part: takes samples, squares deviations and keeps the running pass state
// depends on tpss_pkg; feeds finished passes into tpss_queue
module tpss_front #(
  parameter int unsigned COUNT_MAX      = tpss_pkg::COUNT_MAX_DEF,
  parameter int unsigned MEAN_FRAC_BITS = tpss_pkg::MEAN_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tpss_pkg::in_t       in_data,
  input  logic                q_full,
  output logic                push,
  output tpss_pkg::job_t      push_job,
  input  tpss_pkg::mean_upd_t mean_upd
);

  localparam int SW   = tpss_pkg::SAMPLE_W;
  localparam int CW   = tpss_pkg::CNT_W;
  localparam int SUMW = tpss_pkg::SUM_W;
  localparam int SQW  = tpss_pkg::SQ_W;
  localparam int MW   = tpss_pkg::MEAN_W;
  localparam int DVW  = tpss_pkg::DEV_W;
  localparam int MGW  = tpss_pkg::MAG_W;
  localparam int PW   = tpss_pkg::PROD_W;
  localparam logic [CW-1:0] CAP = CW'(COUNT_MAX);

  logic                   v1, v2;
  logic                   mode1, mode2, last1, last2;
  logic signed [SW-1:0]   s1, s2;
  logic [MGW-1:0]         mag1;
  logic [PW-1:0]          prod2;
  logic signed [SW-1:0]   run_min, run_max, min_next, max_next;
  logic signed [SUMW-1:0] run_sum, sum_next;
  logic [CW-1:0]          count, count_next;
  logic [SQW-1:0]         sq_sum, sq_next;
  logic                   ovf, ovf_next;
  logic signed [MW-1:0]   mean_kept;
  logic                   mean_wait;
  logic                   en, accept, take;
  logic signed [DVW-1:0]  dev;

  // pipeline holds only when a finished pass cannot enter the queue
  assign en       = !(v2 && last2 && q_full);
  // after a pass-one end, later samples need the new mean
  assign in_stall = !en || mean_wait;
  assign accept   = in_valid && !in_stall;
  assign dev      = (DVW'($signed(in_data.sample)) <<< MEAN_FRAC_BITS) - DVW'(mean_kept);
  assign push     = v2 && last2 && !q_full;

  always_comb begin
    take       = count < CAP;
    min_next   = run_min;
    max_next   = run_max;
    sum_next   = run_sum;
    sq_next    = sq_sum;
    count_next = count;
    ovf_next   = ovf;
    if (take) begin
      if (mode2 == tpss_pkg::MODE_PASS1) begin
        if (count == '0) begin
          min_next = s2;
          max_next = s2;
        end else begin
          if (s2 < run_min) min_next = s2;
          if (s2 > run_max) max_next = s2;
        end
        sum_next = run_sum + SUMW'(s2);
      end else begin
        sq_next = sq_sum + SQW'(prod2);
      end
      count_next = count + CW'(1);
    end else begin
      ovf_next = 1'b1;
    end
  end

  always_comb begin
    push_job.kind       = mode2;
    push_job.overflowed = ovf_next;
    push_job.min_value  = min_next;
    push_job.max_value  = max_next;
    push_job.sum        = sum_next;
    push_job.count      = count_next;
    push_job.sq_sum     = sq_next;
    push_job.mean       = mean_kept;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1 <= in_data.mode;
      last1 <= in_data.last;
      s1    <= in_data.sample;
      mag1  <= dev[DVW-1] ? MGW'(-dev) : MGW'(dev);
      mode2 <= mode1;
      last2 <= last1;
      s2    <= s1;
      prod2 <= mag1 * mag1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      run_min   <= '0;
      run_max   <= '0;
      run_sum   <= '0;
      sq_sum    <= '0;
      count     <= '0;
      ovf       <= 1'b0;
      mean_kept <= '0;
      mean_wait <= 1'b0;
    end else begin
      if (en) begin
        v1 <= accept;
        v2 <= v1;
      end
      if (v2 && en) begin
        if (last2) begin
          run_min <= '0;
          run_max <= '0;
          run_sum <= '0;
          sq_sum  <= '0;
          count   <= '0;
          ovf     <= 1'b0;
        end else begin
          run_min <= min_next;
          run_max <= max_next;
          run_sum <= sum_next;
          sq_sum  <= sq_next;
          count   <= count_next;
          ovf     <= ovf_next;
        end
      end
      if (mean_upd.valid) mean_kept <= mean_upd.value;
      if (accept && in_data.last && in_data.mode == tpss_pkg::MODE_PASS1) begin
        mean_wait <= 1'b1;
      end else if (mean_upd.valid) begin
        mean_wait <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/tpss_queue.sv
// short queue of finished passes between front and back
// depends on tpss_pkg
module tpss_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tpss_pkg::job_t push_job,
  output logic           full,
  output logic           q_valid,
  input  logic           pop,
  output tpss_pkg::job_t q_job
);

  localparam int DEPTH = tpss_pkg::QUEUE_DEPTH;
  localparam int PTRW  = $clog2(DEPTH);
  localparam int FILLW = $clog2(DEPTH + 1);

  tpss_pkg::job_t   slot [DEPTH];
  logic [PTRW-1:0]  wr_ptr, rd_ptr;
  logic [FILLW-1:0] fill;

  assign full    = fill == FILLW'(DEPTH);
  assign q_valid = fill != '0;
  assign q_job   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + PTRW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + PTRW'(1);
      case ({push, pop})
        2'b10:   fill <= fill + FILLW'(1);
        2'b01:   fill <= fill - FILLW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

### hw/rtl/tpss_back.sv
// back part: shared radix-2 divider and digit-by-digit square root, output register
// depends on tpss_pkg; takes finished passes from tpss_queue
module tpss_back #(
  parameter int unsigned MEAN_FRAC_BITS = tpss_pkg::MEAN_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                pop,
  input  tpss_pkg::job_t      q_job,
  output logic                out_valid,
  input  logic                out_stall,
  output tpss_pkg::out_t      out_data,
  output tpss_pkg::mean_upd_t mean_upd
);

  localparam int SW    = tpss_pkg::SAMPLE_W;
  localparam int CW    = tpss_pkg::CNT_W;
  localparam int SUMW  = tpss_pkg::SUM_W;
  localparam int SQW   = tpss_pkg::SQ_W;
  localparam int MW    = tpss_pkg::MEAN_W;
  localparam int STW   = tpss_pkg::STD_W;
  localparam int DW    = tpss_pkg::DVSR_W;
  localparam int RW    = tpss_pkg::ROOT_W;
  localparam int RMW   = tpss_pkg::SREM_W;
  localparam int STPW  = tpss_pkg::STEP_W;
  localparam int SQ_SHIFT = 16 - 2 * MEAN_FRAC_BITS;
  localparam logic [STPW-1:0] DIV_END  = STPW'(tpss_pkg::DIV_STEPS - 1);
  localparam logic [STPW-1:0] SQRT_END = STPW'(tpss_pkg::SQRT_STEPS - 1);

  tpss_pkg::back_state_t state, state_next;
  tpss_pkg::job_t        jb;
  logic [SQW-1:0]        num;
  logic [DW-1:0]         rem, dvsr;
  logic [RW-1:0]         root;
  logic [RMW-1:0]        srem;
  logic [STPW-1:0]       step;
  logic                  load_out;

  // setup from the queue head
  logic [SUMW-1:0] sum_mag;
  logic [SQW-1:0]  mean_num, std_num;
  logic            need_div;
  // divider step
  logic [DW:0]     rem_sh, rem_sub;
  logic            qbit;
  logic [DW-1:0]   rem_step;
  // square root step
  logic [RMW+1:0]  srem_sh, trial, srem_sub;
  logic            sbit;
  // result
  logic [MW-2:0]   mean_sat;
  logic signed [MW-1:0] mean_res;
  logic [RW:0]     root_r;
  logic [STW-1:0]  std_res;
  tpss_pkg::out_t  res;

  always_comb begin
    sum_mag  = q_job.sum[SUMW-1] ? SUMW'(-q_job.sum) : q_job.sum;
    mean_num = (SQW'(sum_mag) << (MEAN_FRAC_BITS + 1)) + SQW'(q_job.count);
    std_num  = q_job.sq_sum << SQ_SHIFT;
    if (q_job.kind == tpss_pkg::KIND_STATS) begin
      need_div = q_job.count != '0;
    end else begin
      need_div = q_job.count > CW'(1);
    end

    rem_sh   = {rem, num[SQW-1]};
    rem_sub  = rem_sh - {1'b0, dvsr};
    qbit     = rem_sh >= {1'b0, dvsr};
    rem_step = qbit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];

    srem_sh  = {srem, num[SQW-1:SQW-2]};
    trial    = {2'b00, root, 2'b01};
    srem_sub = srem_sh - trial;
    sbit     = srem_sh >= trial;

    mean_sat = (num > SQW'(tpss_pkg::MEAN_MAX)) ? tpss_pkg::MEAN_MAX : num[MW-2:0];
    mean_res = jb.sum[SUMW-1] ? -MW'(mean_sat) : MW'(mean_sat);
    // round to nearest: bump when the remainder exceeds the floor root
    root_r   = (RW + 1)'(root) + (RW + 1)'(srem > RMW'(root));
    std_res  = (root_r > (RW + 1)'(tpss_pkg::STD_MAX)) ? tpss_pkg::STD_MAX : root_r[STW-1:0];

    res.kind       = jb.kind;
    res.overflowed = jb.overflowed;
    if (jb.kind == tpss_pkg::KIND_STATS) begin
      res.min_value  = jb.min_value;
      res.max_value  = jb.max_value;
      res.mean_value = mean_res;
      res.std_value  = '0;
    end else begin
      res.min_value  = SW'(0);
      res.max_value  = SW'(0);
      res.mean_value = jb.mean;
      res.std_value  = std_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tpss_pkg::BK_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next     = state;
    pop            = 1'b0;
    load_out       = 1'b0;
    mean_upd.valid = 1'b0;
    mean_upd.value = mean_res;
    case (state)
      tpss_pkg::BK_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          state_next = need_div ? tpss_pkg::BK_DIV : tpss_pkg::BK_FIN;
        end
      end
      tpss_pkg::BK_DIV: begin
        if (step == DIV_END) begin
          state_next = (jb.kind == tpss_pkg::KIND_STD) ? tpss_pkg::BK_SQRT : tpss_pkg::BK_FIN;
        end
      end
      tpss_pkg::BK_SQRT: begin
        if (step == SQRT_END) state_next = tpss_pkg::BK_FIN;
      end
      tpss_pkg::BK_FIN: begin
        if (!out_valid || !out_stall) begin
          load_out       = 1'b1;
          mean_upd.valid = jb.kind == tpss_pkg::KIND_STATS;
          state_next     = tpss_pkg::BK_IDLE;
        end
      end
      default: state_next = tpss_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      case (state)
        tpss_pkg::BK_IDLE: step <= '0;
        tpss_pkg::BK_DIV:  step <= step + STPW'(1);
        tpss_pkg::BK_SQRT: step <= step + STPW'(1);
        default:           step <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tpss_pkg::BK_IDLE: begin
        if (q_valid) begin
          jb   <= q_job;
          rem  <= '0;
          root <= '0;
          srem <= '0;
          if (q_job.kind == tpss_pkg::KIND_STATS) begin
            num  <= need_div ? mean_num : '0;
            dvsr <= {q_job.count, 1'b0};
          end else begin
            num  <= std_num;
            dvsr <= DW'(q_job.count - CW'(1));
          end
        end
      end
      tpss_pkg::BK_DIV: begin
        // quotient bits shift in where numerator bits leave
        rem <= rem_step;
        num <= {num[SQW-2:0], qbit};
      end
      tpss_pkg::BK_SQRT: begin
        srem <= sbit ? srem_sub[RMW-1:0] : srem_sh[RMW-1:0];
        root <= {root[RW-2:0], sbit};
        num  <= {num[SQW-3:0], 2'b00};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_data <= res;
  end

endmodule

### hw/rtl/two_pass_sample_statistics_core.sv
// Two-pass sample statistics. Within a pass the core takes one sample per cycle
// while in_stall is low; each sample passes a three-stage front (deviation,
// 25x25 square, accumulate). A sample marked last hands the pass to a two-entry
// queue and the back part, which runs a shared divider one quotient bit per
// cycle and, for a pass-two summary, a square root one result bit per cycle
// (both skipped when there is nothing to divide), then loads the output
// register. After the last sample of pass one the input stalls until the new
// mean is back from the divider, longer while the output is held; after the
// last sample of pass two the next pass can start at once while the back part
// works, up to two finished passes waiting in the queue.
// depends on tpss_pkg, tpss_front, tpss_queue, tpss_back
module two_pass_sample_statistics_core #(
  parameter int unsigned COUNT_MAX      = tpss_pkg::COUNT_MAX_DEF,
  parameter int unsigned MEAN_FRAC_BITS = tpss_pkg::MEAN_FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  tpss_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output tpss_pkg::out_t out_data
);

  logic                q_full, push, q_valid, pop;
  tpss_pkg::job_t      push_job, q_job;
  tpss_pkg::mean_upd_t mean_upd;

  tpss_front #(
    .COUNT_MAX      (COUNT_MAX),
    .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job),
    .mean_upd (mean_upd)
  );

  tpss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .q_valid  (q_valid),
    .pop      (pop),
    .q_job    (q_job)
  );

  tpss_back #(
    .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .pop       (pop),
    .q_job     (q_job),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mean_upd  (mean_upd)
  );

endmodule

### hw/rtl/tpss_checker.sv
// port-level checks of two_pass_sample_statistics_core, bound to the top level
// depends on tpss_pkg and two_pass_sample_statistics_core_defines.svh
`include "two_pass_sample_statistics_core_defines.svh"

module tpss_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_stall,
  input tpss_pkg::out_t out_data
);

  `TPSS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "stalled result dropped")
  `TPSS_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_data), "stalled result changed")
  `TPSS_ASSERT_SAME(a_stats_no_std, clk, rst, out_valid && out_data.kind == tpss_pkg::KIND_STATS, out_data.std_value == '0, "pass one summary carries a deviation")
  `TPSS_ASSERT_SAME(a_std_no_minmax, clk, rst, out_valid && out_data.kind == tpss_pkg::KIND_STD, out_data.min_value == '0 && out_data.max_value == '0, "pass two summary carries min or max")
  `TPSS_ASSERT_SAME(a_min_le_max, clk, rst, out_valid && out_data.kind == tpss_pkg::KIND_STATS, $signed(out_data.min_value) <= $signed(out_data.max_value), "min above max")

endmodule

bind two_pass_sample_statistics_core tpss_checker u_tpss_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
